// ----- hw/rtl/signed_matrix_canonical_form_unit_macros.svh -----
// Assertion macros for the signed matrix canonical form unit.
// Included by the top level; it needs no other file.
`ifndef SIGNED_MATRIX_CANONICAL_FORM_UNIT_MACROS_SVH
`define SIGNED_MATRIX_CANONICAL_FORM_UNIT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SMCF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("smcf: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define SMCF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("smcf: next-cycle check failed");

`endif

// ----- hw/rtl/smcf_pkg.sv -----
// Package for the signed matrix canonical form unit.
// Holds the fixed widths, entry codes and the sign function; depends on nothing.
`default_nettype none

package smcf_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned NumIn  = 5;
  localparam int unsigned PosW   = 5;
  // Up to eight columns of four rows gives at most 32 positive entries.
  localparam int unsigned CntW   = 6;
  localparam logic [PosW-1:0] PosMax = 5'd31;

  // Two-bit entry codes.
  localparam logic [1:0] CodeMinus = 2'd0;
  localparam logic [1:0] CodeZero  = 2'd1;
  localparam logic [1:0] CodePlus  = 2'd2;

  typedef logic [ByteW-1:0] byte_t;

  // Applies a row sign to one entry code; the invalid code reads as minus.
  function automatic logic [1:0] sign_code(input logic [1:0] code, input logic flip);
    logic [1:0] res;
    res = CodeMinus;
    case (code)
      CodeZero:  res = CodeZero;
      CodeMinus: res = flip ? CodePlus : CodeMinus;
      CodePlus:  res = flip ? CodeMinus : CodePlus;
      default:   res = CodeMinus;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/smcf_if.sv -----
// Valid/ready channel interfaces for the canonical form unit.
// Payload types come from smcf_pkg.
`default_nettype none

interface smcf_in_if;
  import smcf_pkg::*;
  logic  valid;
  logic  ready;
  byte_t col0;
  byte_t col1;
  byte_t col2;
  byte_t col3;
  byte_t col4;
  modport source (output valid, col0, col1, col2, col3, col4, input ready);
  modport sink   (input valid, col0, col1, col2, col3, col4, output ready);
endinterface

interface smcf_out_if;
  import smcf_pkg::*;
  logic            valid;
  logic            ready;
  byte_t           canon_col0;
  byte_t           canon_col1;
  byte_t           canon_col2;
  byte_t           canon_col3;
  byte_t           canon_col4;
  logic [PosW-1:0] pos_count;
  modport source (output valid, canon_col0, canon_col1, canon_col2, canon_col3,
                  canon_col4, pos_count, input ready);
  modport sink   (input valid, canon_col0, canon_col1, canon_col2, canon_col3,
                  canon_col4, pos_count, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/signed_matrix_canonical_form_unit.sv -----
// Signed matrix canonical form unit.
// Throughput: one word per cycle while out_o.ready does not stall it; an accepted
// word passes the lane register, then the output register after the merging tree;
// these are the two pipeline stages, each able to hold a word.
// Reset clears both stage valid flags; payload registers are not reset.
`default_nettype none

`include "signed_matrix_canonical_form_unit_macros.svh"

module signed_matrix_canonical_form_unit #(
  parameter int unsigned ROWS = 4,
  parameter int unsigned COLS = 5
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  smcf_in_if.sink    in_i,
  smcf_out_if.source out_o
);
  import smcf_pkg::*;

  localparam int unsigned NLanes = 2 ** ROWS;
  localparam int unsigned KeyW   = CntW + COLS * ByteW;

  logic [NumIn-1:0][ByteW-1:0]  in_cols;
  logic [COLS-1:0][ByteW-1:0]   src;
  logic [NLanes-1:0][KeyW-1:0]  lane_keys;
  logic [KeyW-1:0]              best_key;
  logic [CntW-1:0]              best_cnt;
  logic [COLS*ByteW-1:0]        best_tuple;
  logic [NumIn-1:0][ByteW-1:0]  canon_d;
  logic [NumIn-1:0][ByteW-1:0]  canon_q;
  logic [PosW-1:0]              pos_d;
  logic [PosW-1:0]              pos_q;
  logic                         lane_vld_d;
  logic                         lane_vld_q;
  logic                         out_vld_d;
  logic                         out_vld_q;
  logic                         lane_rdy;
  logic                         out_rdy;
  logic                         in_take;

  // Input columns; columns beyond the fifth read as zero.
  assign in_cols = {in_i.col4, in_i.col3, in_i.col2, in_i.col1, in_i.col0};

  for (genvar c = 0; c < COLS; c++) begin : g_src
    if (c < NumIn) begin : g_used
      assign src[c] = in_cols[c];
    end else begin : g_zero
      assign src[c] = '0;
    end
  end

  // Pipeline handshake: a stage takes a word when empty or when it drains.
  assign out_rdy    = !out_vld_q || out_o.ready;
  assign lane_rdy   = !lane_vld_q || out_rdy;
  assign in_i.ready = lane_rdy;
  assign in_take    = in_i.valid && lane_rdy;

  always_comb begin
    lane_vld_d = lane_rdy ? in_i.valid : lane_vld_q;
    out_vld_d  = out_rdy ? lane_vld_q : out_vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      lane_vld_q <= lane_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // One lane for each row-sign pattern.
  for (genvar l = 0; l < NLanes; l++) begin : g_lane
    smcf_lane #(
      .ROWS  (ROWS),
      .COLS  (COLS),
      .LANE  (l),
      .KEY_W (KeyW)
    ) u_lane (
      .clk_i (clk_i),
      .en_i  (in_take),
      .src_i (src),
      .key_o (lane_keys[l])
    );
  end

  smcf_merge #(
    .NLANES (NLanes),
    .KEY_W  (KeyW)
  ) u_merge (
    .keys_i (lane_keys),
    .best_o (best_key)
  );

  // Unpack the winning key into columns and a saturated count.
  assign best_cnt   = best_key[KeyW-1 -: CntW];
  assign best_tuple = ~best_key[COLS*ByteW-1:0];

  for (genvar k = 0; k < NumIn; k++) begin : g_canon
    if (k < COLS) begin : g_used
      assign canon_d[k] = best_tuple[(COLS-1-k)*ByteW +: ByteW];
    end else begin : g_zero
      assign canon_d[k] = '0;
    end
  end

  assign pos_d = (best_cnt > CntW'(PosMax)) ? PosMax : best_cnt[PosW-1:0];

  always_ff @(posedge clk_i) begin
    if (out_rdy && lane_vld_q) begin
      canon_q <= canon_d;
      pos_q   <= pos_d;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.canon_col0 = canon_q[0];
  assign out_o.canon_col1 = canon_q[1];
  assign out_o.canon_col2 = canon_q[2];
  assign out_o.canon_col3 = canon_q[3];
  assign out_o.canon_col4 = canon_q[4];
  assign out_o.pos_count  = pos_q;

  // A lane word that meets a free output stage is shown in the next cycle.
  `SMCF_ASSERT_NEXT(a_lane_to_out, clk_i, rst_ni, lane_vld_q && out_rdy, out_vld_q)

  // Back-pressure at the input only arises with both the lane and output stages full.
  `SMCF_ASSERT_NOW(a_stall_full, clk_i, rst_ni, !in_i.ready, lane_vld_q && out_vld_q)

  // The shown columns come out of the sort in ascending order.
  `SMCF_ASSERT_NOW(a_sorted, clk_i, rst_ni, out_o.valid,
    (out_o.canon_col0 <= out_o.canon_col1) &&
    (COLS < 3 || out_o.canon_col1 <= out_o.canon_col2) &&
    (COLS < 4 || out_o.canon_col2 <= out_o.canon_col3) &&
    (COLS < 5 || out_o.canon_col3 <= out_o.canon_col4))

  // The count never exceeds the number of entries.
  `SMCF_ASSERT_NOW(a_count_range, clk_i, rst_ni, out_o.valid,
    32'(out_o.pos_count) <= ROWS * COLS)

endmodule

`default_nettype wire

// ----- hw/rtl/smcf_lane.sv -----
// One sign-pattern lane: applies row signs, counts plus entries and sorts
// the columns, then registers the candidate key. Uses smcf_pkg.
`default_nettype none

module smcf_lane #(
  parameter int unsigned ROWS  = 4,
  parameter int unsigned COLS  = 5,
  parameter int unsigned LANE  = 0,
  parameter int unsigned KEY_W = smcf_pkg::CntW + COLS * smcf_pkg::ByteW
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 en_i,
  input  wire logic [COLS-1:0][smcf_pkg::ByteW-1:0] src_i,
  output logic [KEY_W-1:0]                          key_o
);
  import smcf_pkg::*;

  localparam int unsigned RankW = (COLS > 1) ? $clog2(COLS) : 1;
  localparam logic [ROWS-1:0] Flip = ROWS'(LANE);

  logic [COLS-1:0][ByteW-1:0] signed_cols;
  logic [COLS-1:0][ByteW-1:0] sorted_cols;
  logic [COLS-1:0][RankW-1:0] rank;
  logic [CntW-1:0]            plus_cnt;
  logic [COLS*ByteW-1:0]      tuple;
  logic [KEY_W-1:0]           key_d;
  logic [KEY_W-1:0]           key_q;

  // Sign each entry of the used rows; unused rows read as zero.
  always_comb begin
    signed_cols = '0;
    for (int c = 0; c < COLS; c++) begin
      for (int r = 0; r < ROWS; r++) begin
        signed_cols[c][2*r +: 2] = sign_code(src_i[c][2*r +: 2], Flip[r]);
      end
    end
  end

  // Count plus entries; column order does not change the count.
  always_comb begin
    plus_cnt = '0;
    for (int c = 0; c < COLS; c++) begin
      for (int r = 0; r < ROWS; r++) begin
        if (signed_cols[c][2*r +: 2] == CodePlus) begin
          plus_cnt = plus_cnt + CntW'(1);
        end
      end
    end
  end

  // Rank sort: equal columns keep their input order, so ranks are unique.
  always_comb begin
    for (int i = 0; i < COLS; i++) begin
      rank[i] = '0;
      for (int j = 0; j < COLS; j++) begin
        if ((signed_cols[j] < signed_cols[i]) ||
            ((signed_cols[j] == signed_cols[i]) && (j < i))) begin
          rank[i] = rank[i] + RankW'(1);
        end
      end
    end
  end

  always_comb begin
    sorted_cols = '0;
    for (int k = 0; k < COLS; k++) begin
      for (int i = 0; i < COLS; i++) begin
        if (rank[i] == RankW'(k)) begin
          sorted_cols[k] = sorted_cols[k] | signed_cols[i];
        end
      end
    end
  end

  // Column 0 goes to the top of the tuple so a plain compare is lexicographic.
  // The key inverts the tuple so the largest key wins on count, then tuple.
  always_comb begin
    tuple = '0;
    for (int k = 0; k < COLS; k++) begin
      tuple[(COLS-1-k)*ByteW +: ByteW] = sorted_cols[k];
    end
    key_d = {plus_cnt, ~tuple};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      key_q <= key_d;
    end
  end

  assign key_o = key_q;

endmodule

`default_nettype wire

// ----- hw/rtl/smcf_merge.sv -----
// Merging tree over the lane keys: keeps the largest key.
// Stand-alone; key layout is set by smcf_lane.
`default_nettype none

module smcf_merge #(
  parameter int unsigned NLANES = 16,
  parameter int unsigned KEY_W  = 46
) (
  input  wire logic [NLANES-1:0][KEY_W-1:0] keys_i,
  output logic [KEY_W-1:0]                  best_o
);

  logic [KEY_W-1:0] node [2*NLANES-1];

  // Leaves sit at the back of the heap-ordered node array.
  for (genvar l = 0; l < NLANES; l++) begin : g_leaf
    assign node[NLANES-1+l] = keys_i[l];
  end

  // Each inner node keeps the larger of its two children.
  for (genvar n = 0; n < NLANES - 1; n++) begin : g_node
    assign node[n] = (node[2*n+1] >= node[2*n+2]) ? node[2*n+1] : node[2*n+2];
  end

  assign best_o = node[0];

endmodule

`default_nettype wire
